@@ design/char_stream_lexer_assert.svh @@
// Assertion macros shared by the checker files of char_stream_lexer.
// No dependencies; clock and active-low reset are passed in by the user.
`ifndef CHAR_STREAM_LEXER_ASSERT_SVH
`define CHAR_STREAM_LEXER_ASSERT_SVH

// Plain implication checked at every edge outside reset.
`define CSL_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

// Implication whose consequent is checked at the following edge.
`define CSL_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

@@ design/csl_pkg.sv @@
// Shared types and constants of the character stream lexer.
// No dependencies; used by every RTL module of the block.
package csl_pkg;

  localparam int DefMaxNameChars = 8;
  localparam int DefNumberBits   = 32;

  localparam int TokW  = 6;
  localparam int NumW  = 32;
  localparam int TextW = 64;
  localparam int LenW  = 4;

  // token codes
  localparam logic [TokW-1:0] TokEnd   = 6'd0;
  localparam logic [TokW-1:0] TokName  = 6'd10;
  localparam logic [TokW-1:0] TokNum   = 6'd11;
  localparam logic [TokW-1:0] TokPlus  = 6'd13;
  localparam logic [TokW-1:0] TokMinus = 6'd14;
  localparam logic [TokW-1:0] TokStar  = 6'd15;
  localparam logic [TokW-1:0] TokSlash = 6'd16;
  localparam logic [TokW-1:0] TokLe    = 6'd17;
  localparam logic [TokW-1:0] TokLt    = 6'd18;
  localparam logic [TokW-1:0] TokGt    = 6'd19;
  localparam logic [TokW-1:0] TokGe    = 6'd20;
  localparam logic [TokW-1:0] TokNe    = 6'd21;
  localparam logic [TokW-1:0] TokColon = 6'd22;
  localparam logic [TokW-1:0] TokSemi  = 6'd23;
  localparam logic [TokW-1:0] TokCmt   = 6'd24;
  localparam logic [TokW-1:0] TokLBrc  = 6'd25;
  localparam logic [TokW-1:0] TokRBrc  = 6'd26;
  localparam logic [TokW-1:0] TokLPar  = 6'd27;
  localparam logic [TokW-1:0] TokRPar  = 6'd28;
  localparam logic [TokW-1:0] TokPct   = 6'd31;
  localparam logic [TokW-1:0] TokAsgn  = 6'd32;
  localparam logic [TokW-1:0] TokEqEq  = 6'd33;
  localparam logic [TokW-1:0] TokLBrk  = 6'd35;
  localparam logic [TokW-1:0] TokInc   = 6'd37;
  localparam logic [TokW-1:0] TokDec   = 6'd38;
  localparam logic [TokW-1:0] TokErr   = 6'd39;

  // characters the lexer looks at
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChLPar  = 8'h28;
  localparam logic [7:0] ChRPar  = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChLBrk  = 8'h5b;
  localparam logic [7:0] ChLBrc  = 8'h7b;
  localparam logic [7:0] ChRBrc  = 8'h7d;

  // keywords, first character in the low byte
  localparam int NumKw = 6;
  localparam logic [TextW-1:0] KwText [NumKw] = '{
    64'h0000_0000_0000_6669,   // if
    64'h0000_0000_6573_6c65,   // else
    64'h0000_0065_6c69_6877,   // while
    64'h0000_0000_0000_6f64,   // do
    64'h0000_0000_0072_6f66,   // for
    64'h0000_6863_7469_7773    // switch
  };
  localparam logic [LenW-1:0] KwLen [NumKw] = '{4'd2, 4'd4, 4'd5, 4'd2, 4'd3, 4'd6};

  typedef enum logic [11:0] {
    MODE_IDLE  = 12'b0000_0000_0001,
    MODE_NAME  = 12'b0000_0000_0010,
    MODE_NUM   = 12'b0000_0000_0100,
    MODE_LT    = 12'b0000_0000_1000,
    MODE_GT    = 12'b0000_0001_0000,
    MODE_EQ    = 12'b0000_0010_0000,
    MODE_PLUS  = 12'b0000_0100_0000,
    MODE_MINUS = 12'b0000_1000_0000,
    MODE_BANG  = 12'b0001_0000_0000,
    MODE_SLASH = 12'b0010_0000_0000,
    MODE_CMT   = 12'b0100_0000_0000,
    MODE_CSTAR = 12'b1000_0000_0000
  } mode_e;

  // classified character as it travels from front to back
  typedef struct packed {
    logic            eot;
    logic [7:0]      ch;
    logic            letter;
    logic            digit;
    mode_e           start_mode;
    logic            start_emit;
    logic [TokW-1:0] start_code;
  } item_t;

  typedef struct packed {
    logic [TokW-1:0]  code;
    logic [NumW-1:0]  num;
    logic [TextW-1:0] text;
    logic [LenW-1:0]  len;
    logic             last;
  } tok_t;

endpackage

@@ design/csl_front.sv @@
// Front end of the lexer: classifies each character and queues it.
// Depends on csl_pkg.
module csl_front import csl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_ready_i
);

  item_t      cls;
  item_t      q_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    cls            = '0;
    cls.eot        = end_of_text_i;
    cls.ch         = char_code_i;
    cls.letter     = (char_code_i >= 8'h41 && char_code_i <= 8'h5a) ||
                     (char_code_i >= 8'h61 && char_code_i <= 8'h7a);
    cls.digit      = char_code_i >= 8'h30 && char_code_i <= 8'h39;
    cls.start_mode = MODE_IDLE;
    cls.start_emit = 1'b0;
    cls.start_code = TokErr;
    if (cls.letter) begin
      cls.start_mode = MODE_NAME;
    end else if (cls.digit) begin
      cls.start_mode = MODE_NUM;
    end else begin
      unique case (char_code_i) inside
        ChSpace, ChNl: ;
        ChLt:    cls.start_mode = MODE_LT;
        ChGt:    cls.start_mode = MODE_GT;
        ChEq:    cls.start_mode = MODE_EQ;
        ChPlus:  cls.start_mode = MODE_PLUS;
        ChMinus: cls.start_mode = MODE_MINUS;
        ChBang:  cls.start_mode = MODE_BANG;
        ChSlash: cls.start_mode = MODE_SLASH;
        ChColon: begin cls.start_emit = 1'b1; cls.start_code = TokColon; end
        ChSemi:  begin cls.start_emit = 1'b1; cls.start_code = TokSemi;  end
        ChLBrc:  begin cls.start_emit = 1'b1; cls.start_code = TokLBrc;  end
        ChRBrc:  begin cls.start_emit = 1'b1; cls.start_code = TokRBrc;  end
        ChLPar:  begin cls.start_emit = 1'b1; cls.start_code = TokLPar;  end
        ChRPar:  begin cls.start_emit = 1'b1; cls.start_code = TokRPar;  end
        ChPct:   begin cls.start_emit = 1'b1; cls.start_code = TokPct;   end
        ChLBrk:  begin cls.start_emit = 1'b1; cls.start_code = TokLBrk;  end
        ChAt:    begin cls.start_emit = 1'b1; cls.start_code = TokEnd;   end
        ChStar:  begin cls.start_emit = 1'b1; cls.start_code = TokStar;  end
        default: begin cls.start_emit = 1'b1; cls.start_code = TokErr;   end
      endcase
    end
  end

  assign full         = (cnt_q == 2'd2);
  assign do_push      = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_q[rd_q];
  assign do_pop       = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ design/csl_back.sv @@
// Back end of the lexer: mode machine that builds and emits tokens.
// Depends on csl_pkg; feeds csl_tok_queue with up to two tokens a cycle.
module csl_back import csl_pkg::*; #(
  parameter int MaxNameChars = DefMaxNameChars,
  parameter int NumberBits   = DefNumberBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_ready_o,
  input  logic       tok_room_i,
  output logic [1:0] tok_cnt_o,
  output tok_t       tok0_o,
  output tok_t       tok1_o
);

  localparam int NameW = MaxNameChars * 8;
  localparam int WideW = NumberBits + 4;
  localparam logic [LenW-1:0] MaxCnt = LenW'(MaxNameChars);

  mode_e                 mode_q, mode_d;
  logic [NameW-1:0]      name_q, name_d;
  logic [LenW-1:0]       cnt_q, cnt_d;
  logic [NumberBits-1:0] acc_q, acc_d;

  logic            fire;
  logic            fl, stt, dir_v;
  logic [TokW-1:0] dir_code;
  logic            flush_v;
  tok_t            flush_tok, start_tok, dir_tok;
  logic            kw_hit;
  logic [TokW-1:0] kw_code;
  logic [7:0]      pair_ch;
  logic [TokW-1:0] pair_code;
  logic [WideW-1:0] acc_w, acc_mul;
  logic [63:0]     acc_ext;
  logic            fv, sv;
  logic [1:0]      n;

  assign fire         = item_valid_i && tok_room_i;
  assign item_ready_o = tok_room_i;

  // keyword match on the held name
  always_comb begin
    kw_hit  = 1'b0;
    kw_code = TokName;
    for (int k = 0; k < NumKw; k++) begin
      if (TextW'(name_q) == KwText[k] && cnt_q == KwLen[k] && cnt_q <= MaxCnt) begin
        kw_hit  = 1'b1;
        kw_code = TokW'(k + 1);
      end
    end
  end

  // saturating decimal step: acc*10 + digit
  assign acc_w   = WideW'(acc_q);
  assign acc_mul = (acc_w << 3) + (acc_w << 1) + WideW'(item_i.ch[3:0]);
  assign acc_ext = 64'(acc_q);

  // token held by the current mode
  always_comb begin
    flush_tok = '0;
    flush_v   = 1'b1;
    unique case (mode_q) inside
      MODE_NAME: begin
        flush_tok.code = kw_hit ? kw_code : TokName;
        flush_tok.text = TextW'(name_q);
        flush_tok.len  = (cnt_q > MaxCnt) ? MaxCnt : cnt_q;
      end
      MODE_NUM: begin
        flush_tok.code = TokNum;
        flush_tok.num  = acc_ext[NumW-1:0];
      end
      MODE_LT:    flush_tok.code = TokLt;
      MODE_GT:    flush_tok.code = TokGt;
      MODE_EQ:    flush_tok.code = TokAsgn;
      MODE_PLUS:  flush_tok.code = TokPlus;
      MODE_MINUS: flush_tok.code = TokMinus;
      MODE_SLASH: flush_tok.code = TokSlash;
      MODE_BANG, MODE_CMT, MODE_CSTAR: flush_tok.code = TokErr;
      default:    flush_v = 1'b0;
    endcase
  end

  // second character of a two-character operator
  always_comb begin
    pair_ch   = ChEq;
    pair_code = TokErr;
    unique case (mode_q)
      MODE_LT:    pair_code = TokLe;
      MODE_GT:    pair_code = TokGe;
      MODE_EQ:    pair_code = TokEqEq;
      MODE_BANG:  pair_code = TokNe;
      MODE_PLUS:  begin pair_ch = ChPlus;  pair_code = TokInc; end
      MODE_MINUS: begin pair_ch = ChMinus; pair_code = TokDec; end
      default: ;
    endcase
  end

  always_comb begin
    start_tok      = '0;
    start_tok.code = item_i.start_code;
    dir_tok        = '0;
    dir_tok.code   = dir_code;
  end

  // next state
  always_comb begin
    mode_d   = mode_q;
    name_d   = name_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    fl       = 1'b0;
    stt      = 1'b0;
    dir_v    = 1'b0;
    dir_code = TokErr;
    if (item_i.eot) begin
      fl = 1'b1;
    end else begin
      unique case (mode_q) inside
        MODE_NAME: begin
          if (item_i.letter || item_i.digit) begin
            if (cnt_q < MaxCnt) begin
              for (int i = 0; i < MaxNameChars; i++) begin
                if (cnt_q == LenW'(i)) name_d[i*8 +: 8] = item_i.ch;
              end
              cnt_d = cnt_q + 1'b1;
            end else begin
              cnt_d = MaxCnt + 1'b1;
            end
          end else begin
            fl  = 1'b1;
            stt = 1'b1;
          end
        end
        MODE_NUM: begin
          if (item_i.digit) begin
            acc_d = (|acc_mul[WideW-1:NumberBits]) ? '1 : acc_mul[NumberBits-1:0];
          end else begin
            fl  = 1'b1;
            stt = 1'b1;
          end
        end
        MODE_LT, MODE_GT, MODE_EQ, MODE_PLUS, MODE_MINUS, MODE_BANG: begin
          if (item_i.ch == pair_ch) begin
            dir_v    = 1'b1;
            dir_code = pair_code;
            mode_d   = MODE_IDLE;
          end else begin
            fl  = 1'b1;
            stt = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (item_i.ch == ChStar) begin
            mode_d = MODE_CMT;
          end else begin
            fl  = 1'b1;
            stt = 1'b1;
          end
        end
        MODE_CMT: begin
          if (item_i.ch == ChStar) begin
            mode_d = MODE_CSTAR;
          end else if (item_i.ch == ChAt) begin
            dir_v  = 1'b1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_CSTAR: begin
          if (item_i.ch == ChSlash) begin
            dir_v    = 1'b1;
            dir_code = TokCmt;
            mode_d   = MODE_IDLE;
          end else if (item_i.ch == ChAt) begin
            dir_v  = 1'b1;
            mode_d = MODE_IDLE;
          end else if (item_i.ch != ChStar) begin
            mode_d = MODE_CMT;
          end
        end
        default: stt = 1'b1;   // idle and unused codes
      endcase
    end

    if (stt) begin
      mode_d = item_i.start_mode;
      name_d = item_i.letter ? NameW'(item_i.ch) : '0;
      cnt_d  = item_i.letter ? LenW'(1) : '0;
      acc_d  = item_i.digit ? NumberBits'(item_i.ch[3:0]) : '0;
    end else if (fl || dir_v) begin
      mode_d = MODE_IDLE;
      name_d = '0;
      cnt_d  = '0;
      acc_d  = '0;
    end
  end

  // token list: held token first, then a token started by this character; a pair or comment token goes alone
  assign fv = fl && flush_v;
  assign sv = stt && item_i.start_emit;
  assign n  = 2'(fv) + 2'(sv) + 2'(dir_v);

  always_comb begin
    tok0_o      = fv ? flush_tok : (sv ? start_tok : dir_tok);
    tok0_o.last = (n == 2'd1);
    tok1_o      = start_tok;
    tok1_o.last = 1'b1;
    tok_cnt_o   = fire ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      name_q <= '0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      name_q <= name_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

endmodule

@@ design/csl_tok_queue.sv @@
// Four-entry token queue: takes up to two tokens a cycle, gives one.
// Depends on csl_pkg.
module csl_tok_queue import csl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_cnt_i,
  input  tok_t       tok0_i,
  input  tok_t       tok1_i,
  output logic       room_o,
  output logic       empty,
  input  logic       pop,
  output tok_t       head_o
);

  tok_t       q_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign empty  = (cnt_q == 3'd0);
  assign room_o = (cnt_q <= 3'd2);
  assign head_o = q_q[rd_q];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      q_q[wr_q] <= tok0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      q_q[wr_q + 2'd1] <= tok1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_q + wr_cnt_i;
      if (do_pop) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(wr_cnt_i) - 3'(do_pop);
    end
  end

endmodule

@@ design/char_stream_lexer.sv @@
// char_stream_lexer: one character a word in, tokens out.
// Input queue: char_code_i / end_of_text_i, taken when push is high and full low.
//   end_of_text_i flushes the pending token; char_code_i is then ignored.
// Output queue: the oldest token sits on the result ports while empty is low
//   and leaves on a clock edge with pop high. A character gives zero, one or
//   two tokens; last_of_run_o marks the final token of one character.
// Path: a taken character is registered in the character queue, the mode
//   machine writes its tokens into the token queue, whose head drives the ports.
// Throughput: one character per cycle while each gives at most one token and
//   pop stays high; a character that gives two tokens writes both in the same
//   cycle, but only one leaves per cycle, so a run of those follows the pop rate.
// Structure: a classifier writes a two-entry character queue; the mode machine
//   reads one character a cycle and writes up to two tokens into a four-entry
//   token queue, and only advances when that queue has room for two.
// Reset: both queues empty, mode idle, name and number accumulators cleared.
// Stalls: when pop stays low the token queue fills, the mode machine halts,
//   the character queue fills and full rises; nothing is dropped.
// Depends on csl_pkg, csl_front, csl_back and csl_tok_queue.
module char_stream_lexer import csl_pkg::*; #(
  parameter int MaxNameChars = DefMaxNameChars,
  parameter int NumberBits   = DefNumberBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_text_i,
  output logic             empty,
  input  logic             pop,
  output logic [TokW-1:0]  token_code_o,
  output logic [NumW-1:0]  number_value_o,
  output logic [TextW-1:0] name_text_o,
  output logic [LenW-1:0]  name_length_o,
  output logic             last_of_run_o
);

  item_t      item;
  logic       item_valid, item_ready;
  logic       tok_room;
  logic [1:0] tok_cnt;
  tok_t       tok0, tok1, head;

  // classify and buffer characters
  csl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_ready_i  (item_ready)
  );

  // lexer mode machine
  csl_back #(
    .MaxNameChars (MaxNameChars),
    .NumberBits   (NumberBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .tok_room_i   (tok_room),
    .tok_cnt_o    (tok_cnt),
    .tok0_o       (tok0),
    .tok1_o       (tok1)
  );

  // result queue, head drives the ports directly
  csl_tok_queue u_tokq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (tok_cnt),
    .tok0_i   (tok0),
    .tok1_i   (tok1),
    .room_o   (tok_room),
    .empty    (empty),
    .pop      (pop),
    .head_o   (head)
  );

  assign token_code_o   = head.code;
  assign number_value_o = head.num;
  assign name_text_o    = head.text;
  assign name_length_o  = head.len;
  assign last_of_run_o  = head.last;

endmodule

@@ design/csl_checker.sv @@
// Port-level checks of char_stream_lexer, bound to the top level.
// Depends on csl_pkg and char_stream_lexer_assert.svh.
`include "char_stream_lexer_assert.svh"

module csl_checker import csl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [TokW-1:0]  token_code_o,
  input logic [NumW-1:0]  number_value_o,
  input logic [TextW-1:0] name_text_o,
  input logic [LenW-1:0]  name_length_o
);

  // a waiting token stays put until popped
  `CSL_ASSERT_NEXT(a_head_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_code_o) && $stable(name_text_o), "token changed while waiting")

  // only names and keywords carry a length
  `CSL_ASSERT_NOW(a_len_name, clk_i, rst_ni, !empty && name_length_o != 4'd0, token_code_o == TokName || (token_code_o >= 6'd1 && token_code_o <= 6'd6), "length on non-name token")

  // only numbers carry a value
  `CSL_ASSERT_NOW(a_num_only, clk_i, rst_ni, !empty && number_value_o != 32'd0, token_code_o == TokNum, "value on non-number token")

  // numbers carry no text
  `CSL_ASSERT_NOW(a_num_notext, clk_i, rst_ni, !empty && token_code_o == TokNum, name_text_o == 64'd0 && name_length_o == 4'd0, "text on number token")

endmodule

bind char_stream_lexer csl_checker u_csl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .token_code_o   (token_code_o),
  .number_value_o (number_value_o),
  .name_text_o    (name_text_o),
  .name_length_o  (name_length_o)
);

@@ bench/tb.sv @@
// Self-checking bench for char_stream_lexer: random and directed character words
// in, every popped token compared with a cycle-free token predictor.
// Depends on csl_pkg (token codes, character codes, mode_e, tok_t) and the RTL.
`timescale 1ns / 1ps

import csl_pkg::*;

// keyword token codes, in the order if, else, while, do, for, switch
localparam logic [TokW-1:0] TokIf     = 6'd1;
localparam logic [TokW-1:0] TokElse   = 6'd2;
localparam logic [TokW-1:0] TokWhile  = 6'd3;
localparam logic [TokW-1:0] TokDo     = 6'd4;
localparam logic [TokW-1:0] TokFor    = 6'd5;
localparam logic [TokW-1:0] TokSwitch = 6'd6;

localparam int unsigned NameMax = DefMaxNameChars;

// Token predictor plus the store of tokens still owed by the DUT.
class token_scoreboard;
  tok_t             expected_tokens[$];
  int unsigned      errors;
  mode_e            mode;
  logic [TextW-1:0] name_buf;
  int unsigned      name_cnt;
  logic [NumW-1:0]  num_acc;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    mode     = MODE_IDLE;
    name_buf = '0;
    name_cnt = 0;
    num_acc  = '0;
  endfunction

  function bit letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void add(logic [TokW-1:0] code, logic [NumW-1:0] num = '0,
                    logic [TextW-1:0] text = '0, logic [LenW-1:0] len = '0);
    tok_t t;
    t.code = code;
    t.num  = num;
    t.text = text;
    t.len  = len;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  // held name matches a keyword exactly (text and length)
  function bit is_word(string s);
    logic [TextW-1:0] v;
    v = '0;
    for (int i = 0; i < s.len(); i++) v |= {56'd0, s[i]} << (8 * i);
    return name_cnt == s.len() && name_buf == v;
  endfunction

  function logic [TokW-1:0] name_code();
    if (name_cnt > NameMax) return TokName;   // truncated: never a keyword
    if (is_word("if"))     return TokIf;
    if (is_word("else"))   return TokElse;
    if (is_word("while"))  return TokWhile;
    if (is_word("do"))     return TokDo;
    if (is_word("for"))    return TokFor;
    if (is_word("switch")) return TokSwitch;
    return TokName;
  endfunction

  // emit whatever the current mode holds, back to idle
  function void emit_held();
    case (mode) inside
      MODE_NAME:  add(name_code(), '0, name_buf, LenW'(name_cnt > NameMax ? NameMax : name_cnt));
      MODE_NUM:   add(TokNum, num_acc);
      MODE_LT:    add(TokLt);
      MODE_GT:    add(TokGt);
      MODE_EQ:    add(TokAsgn);
      MODE_PLUS:  add(TokPlus);
      MODE_MINUS: add(TokMinus);
      MODE_BANG:  add(TokErr);
      MODE_SLASH: add(TokSlash);
      MODE_CMT,
      MODE_CSTAR: add(TokErr);      // open comment
      default: ;
    endcase
    clear();
  endfunction

  // character seen from idle
  function void begin_char(logic [7:0] c);
    clear();
    if (c == ChSpace || c == ChNl) return;
    if (letter(c)) begin
      mode     = MODE_NAME;
      name_buf = {56'd0, c};
      name_cnt = 1;
      return;
    end
    if (digit(c)) begin
      mode    = MODE_NUM;
      num_acc = NumW'(c - "0");
      return;
    end
    case (c)
      ChLt:    mode = MODE_LT;
      ChGt:    mode = MODE_GT;
      ChEq:    mode = MODE_EQ;
      ChPlus:  mode = MODE_PLUS;
      ChMinus: mode = MODE_MINUS;
      ChBang:  mode = MODE_BANG;
      ChSlash: mode = MODE_SLASH;
      ChColon: add(TokColon);
      ChSemi:  add(TokSemi);
      ChLBrc:  add(TokLBrc);
      ChRBrc:  add(TokRBrc);
      ChLPar:  add(TokLPar);
      ChRPar:  add(TokRPar);
      ChPct:   add(TokPct);
      ChLBrk:  add(TokLBrk);
      ChAt:    add(TokEnd);
      ChStar:  add(TokStar);
      default: add(TokErr);
    endcase
  endfunction

  function void pair_or_restart(logic [7:0] c, logic [7:0] second, logic [TokW-1:0] code2);
    if (c == second) begin
      add(code2);
      clear();
    end else begin
      emit_held();
      begin_char(c);
    end
  endfunction

  // one accepted input word
  function void lex_word(logic [7:0] c, logic eot);
    int unsigned first;
    logic [63:0] wide;
    first = expected_tokens.size();
    if (eot) begin
      emit_held();
    end else begin
      case (mode)
        MODE_NAME: begin
          if (letter(c) || digit(c)) begin
            if (name_cnt < NameMax) begin
              name_buf |= {56'd0, c} << (8 * name_cnt);
              name_cnt++;
            end else begin
              name_cnt = NameMax + 1;
            end
          end else begin
            emit_held();
            begin_char(c);
          end
        end
        MODE_NUM: begin
          if (digit(c)) begin
            wide = 64'(num_acc) * 64'd10 + 64'(c - "0");
            num_acc = (wide > 64'(NumW'('1))) ? '1 : wide[NumW-1:0];
          end else begin
            emit_held();
            begin_char(c);
          end
        end
        MODE_LT:    pair_or_restart(c, ChEq, TokLe);
        MODE_GT:    pair_or_restart(c, ChEq, TokGe);
        MODE_EQ:    pair_or_restart(c, ChEq, TokEqEq);
        MODE_PLUS:  pair_or_restart(c, ChPlus, TokInc);
        MODE_MINUS: pair_or_restart(c, ChMinus, TokDec);
        MODE_BANG:  pair_or_restart(c, ChEq, TokNe);
        MODE_SLASH: begin
          if (c == ChStar) mode = MODE_CMT;
          else begin
            emit_held();
            begin_char(c);
          end
        end
        MODE_CMT: begin
          if (c == ChStar) mode = MODE_CSTAR;
          else if (c == ChAt) begin
            add(TokErr);
            clear();
          end
        end
        MODE_CSTAR: begin
          if (c == ChSlash) begin
            add(TokCmt);
            clear();
          end else if (c == ChAt) begin
            add(TokErr);
            clear();
          end else if (c != ChStar) begin
            mode = MODE_CMT;
          end
        end
        default: begin_char(c);
      endcase
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  function void check_token(tok_t got);
    tok_t e;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token, token_code %0d", got.code);
      errors++;
      return;
    end
    e = expected_tokens.pop_front();
    if (got.code != e.code) begin
      $error("token_code: expected %0d, got %0d", e.code, got.code);
      errors++;
    end
    if (got.num != e.num) begin
      $error("number_value: expected %0d, got %0d", e.num, got.num);
      errors++;
    end
    if (got.text != e.text) begin
      $error("name_text: expected %h, got %h", e.text, got.text);
      errors++;
    end
    if (got.len != e.len) begin
      $error("name_length: expected %0d, got %0d", e.len, got.len);
      errors++;
    end
    if (got.last != e.last) begin
      $error("last_of_run: expected %0d, got %0d", e.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       char_code_i = 8'd0;
  logic             end_of_text_i = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [TokW-1:0]  token_code_o;
  logic [NumW-1:0]  number_value_o;
  logic [TextW-1:0] name_text_o;
  logic [LenW-1:0]  name_length_o;
  logic             last_of_run_o;

  token_scoreboard scoreboard = new();

  int unsigned words_taken = 0;   // words accepted by the DUT
  int unsigned burst_left  = 0;   // words left in the current sender burst

  string op_text[14] = '{"<", "<=", ">", ">=", "=", "==", "+", "++", "-", "--",
                         "!", "!=", "*", "/"};
  string kw_text[6]  = '{"if", "else", "while", "do", "for", "switch"};
  string punct_text  = ":;{}()%[@";

  char_stream_lexer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .token_code_o  (token_code_o),
    .number_value_o(number_value_o),
    .name_text_o   (name_text_o),
    .name_length_o (name_length_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both handshakes are judged on pre-edge values, so the predictor sees
  // exactly the words and tokens the DUT moves at this edge.
  always @(posedge clk_i) begin
    tok_t got;
    if (rst_ni) begin
      if (push && !full) begin
        scoreboard.lex_word(char_code_i, end_of_text_i);
        words_taken++;
      end
      if (pop && !empty) begin
        got.code = token_code_o;
        got.num  = number_value_o;
        got.text = name_text_o;
        got.len  = name_length_o;
        got.last = last_of_run_o;
        scoreboard.check_token(got);
      end
    end
  end

  // Offer one word and hold it until the DUT takes it. Bursts of random
  // length, with random gaps (often none) between them.
  task automatic send_word(input logic [7:0] c, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
    end
    burst_left--;
    char_code_i   <= c;
    end_of_text_i <= eot;
    push          <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_letter();
    int unsigned k;
    k = $urandom_range(0, 51);
    send_word(k < 26 ? 8'("A") + 8'(k) : 8'("a") + 8'(k - 26), 1'b0);
  endtask

  task automatic send_digit();
    send_word(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  // One lexeme with random content; mostly well formed, some noise.
  task automatic send_lexeme();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      send_text(kw_text[$urandom_range(0, 5)]);
      if ($urandom_range(0, 4) == 0) send_letter();    // near miss: becomes a name
    end else if (kind < 30) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
      send_letter();
      for (int i = 1; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) send_digit();
        else send_letter();
      end
    end else if (kind < 45) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_digit();
    end else if (kind < 65) begin
      send_text(op_text[$urandom_range(0, 13)]);
    end else if (kind < 75) begin
      send_word(punct_text[$urandom_range(0, punct_text.len() - 1)], 1'b0);
    end else if (kind < 85) begin
      send_text("/*");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0) send_word(ChStar, 1'b0);
        else send_word(8'($urandom_range(0, 255)), 1'b0);
      end
      n = $urandom_range(0, 19);
      if (n < 14)      send_text("*/");
      else if (n < 17) send_text("**/");
      else if (n < 19) send_word(ChAt, 1'b0);   // unterminated comment
      // else: left open for the next words or an end of text
    end else if (kind < 93) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin : stimulus
    int unsigned sep;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturating number, letter right after it, truncated name
    // flushed by end of text, lone bang before an unknown code (two tokens),
    // comment closed by a run of stars
    send_text("9999999999Zz9yyyyyy");
    send_word(8'hff, 1'b1);
    send_word(ChBang, 1'b0);
    send_word(8'hff, 1'b0);
    send_text("/***/");

    while (words_taken < 500) begin
      send_lexeme();
      sep = $urandom_range(0, 99);
      if (sep < 40)      send_word(ChSpace, 1'b0);
      else if (sep < 55) send_word(ChNl, 1'b0);
    end
    send_word(8'h00, 1'b1);
    push <= 1'b0;
    // let the monitor log the last word before looking at the owed tokens
    @(posedge clk_i);

    while (scoreboard.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (scoreboard.errors == 0 && scoreboard.expected_tokens.size() == 0)
      $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Receiver: stretches of always-pop, random pop, periodic pop and mostly-pop,
  // plus one long hold-off so the token and character queues fill and full rises.
  initial begin : drain
    int unsigned stretch;
    int unsigned style;
    bit          held_off;
    held_off = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_off && words_taken >= 150) begin
        pop <= 1'b0;
        repeat (100) @(posedge clk_i);
        held_off = 1'b1;
      end
      stretch = $urandom_range(10, 60);
      style   = $urandom_range(0, 3);
      for (int i = 0; i < stretch; i++) begin
        case (style)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (i % 3 == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
